// ===== rtl/core/em4100_pkg.sv =====
// Shared types, constants and frame check for the EM4100 pulse frame decoder.
`default_nettype none
package em4100_pkg;

    localparam int DUR_W      = 16;
    localparam int ID_W       = 40;
    localparam int HELD_W     = 9;
    localparam int START_W    = 7;
    localparam int IDX_W      = 2;
    localparam int FRAME_BITS = 64;
    localparam int MIN_CHIPS  = 128;
    localparam int MAX_REPS   = 6;
    localparam int HDR_ONES   = 9;
    localparam int COL_BASE   = 59;
    localparam int ROWS       = 10;

    localparam logic [IDX_W-1:0] REG_MIN_PULSE = 2'd0;
    localparam logic [IDX_W-1:0] REG_MAX_PULSE = 2'd1;
    localparam logic [IDX_W-1:0] REG_HALF_BIT  = 2'd2;

    localparam logic [DUR_W-1:0] MIN_PULSE_RST = 16'd100;
    localparam logic [DUR_W-1:0] MAX_PULSE_RST = 16'd1800;
    localparam logic [DUR_W-1:0] HALF_BIT_RST  = 16'd256;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_PUSH,
        ST_LOAD,
        ST_STEP
    } state_t;

    typedef struct packed {
        logic push;
        logic full;
        logic chip;
        logic scan_load;
        logic scan_off;
        logic scan_shift;
    } cell_ctl_t;

    // Bit i of the frame is fr[63-i]; bd marks invalid (equal) chip pairs.
    function automatic logic frame_ok(input logic [FRAME_BITS-1:0] fr,
                                      input logic [FRAME_BITS-1:0] bd);
        logic       ok;
        logic [3:0] col;
        logic       par;
        int         r;
        int         k;
        ok  = (bd == '0) && (fr[FRAME_BITS-1:FRAME_BITS-HDR_ONES] == '1) && !fr[0];
        col = '0;
        for (r = 0; r < ROWS; r++)
        begin
            par = fr[FRAME_BITS-1-(HDR_ONES+r*5+4)];
            for (k = 0; k < 4; k++)
            begin
                par    = par ^ fr[FRAME_BITS-1-(HDR_ONES+r*5+k)];
                col[k] = col[k] ^ fr[FRAME_BITS-1-(HDR_ONES+r*5+k)];
            end
            if (par)
            begin
                ok = 1'b0;
            end
        end
        for (k = 0; k < 4; k++)
        begin
            if (col[k] ^ fr[FRAME_BITS-1-(COL_BASE+k)])
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic logic [ID_W-1:0] frame_id(input logic [FRAME_BITS-1:0] fr);
        logic [ID_W-1:0] v;
        int              r;
        int              k;
        v = '0;
        for (r = 0; r < ROWS; r++)
        begin
            for (k = 0; k < 4; k++)
            begin
                v[ID_W-1-(r*4+k)] = fr[FRAME_BITS-1-(HDR_ONES+r*5+k)];
            end
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/em4100_if.sv =====
// Handshake interfaces for pulse requests and decoded tag results.
`default_nettype none
interface em4100_pulse_if;
    logic        valid;
    logic        ready;
    logic        pulse_level;
    logic [15:0] pulse_duration;

    modport source (output valid, output pulse_level, output pulse_duration, input ready);
    modport sink (input valid, input pulse_level, input pulse_duration, output ready);
endinterface

interface em4100_tag_if;
    logic        valid;
    logic        ready;
    logic [39:0] tag_id;
    logic [8:0]  chips_held;
    logic        pair_phase;
    logic        polarity_sel;
    logic [6:0]  header_pos;

    modport source (output valid, output tag_id, output chips_held, output pair_phase,
                    output polarity_sel, output header_pos, input ready);
    modport sink (input valid, input tag_id, input chips_held, input pair_phase,
                  input polarity_sel, input header_pos, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/em4100_pulse_frame_decoder_unit.sv =====
// Top level of the EM4100 pulse frame decoder: rounding, chip chain and frame search.
// Each accepted pulse is either dropped or rounded against the half-bit length,
// and the rounded number of chips is then pushed into the cell chain one by
// one. Once 128 chips are held, a search of four decodings follows, in which
// the scan chain hands on one chip pair per cycle. A new pulse request is taken
// when the search ends; a finished result waits in the output register while
// the next pulse is processed.
`default_nettype none
module em4100_pulse_frame_decoder_unit #(
    parameter int WINDOW_CHIPS = 256,
    parameter int WINDOW_BITS  = 128
) (
    input  wire                         clk,
    input  wire                         rst_n,
    em4100_pulse_if.sink                pulse,
    em4100_tag_if.source                tag,
    input  wire                         cfg_we,
    input  wire [em4100_pkg::IDX_W-1:0] cfg_index,
    input  wire [em4100_pkg::DUR_W-1:0] cfg_data
);
    import em4100_pkg::*;

    localparam int FW = $clog2(WINDOW_CHIPS + 1);
    localparam int CW = FW + 1;
    localparam int NW = $clog2(WINDOW_BITS + 1);

    logic [DUR_W-1:0] min_reg;
    logic [DUR_W-1:0] max_reg;
    logic [DUR_W-1:0] hb_reg;

    state_t           state_reg, state_next;
    logic [FW-1:0]    fill_reg, fill_next;
    logic             level_reg, level_next;
    logic [DUR_W:0]   tgt_reg, tgt_next;
    logic [DUR_W+3:0] thr_reg, thr_next;
    logic [DUR_W-1:0] step_reg, step_next;
    logic [2:0]       k_reg, k_next;
    logic [2:0]       reps_reg, reps_next;
    logic             off_reg, off_next;
    logic             map_reg, map_next;
    logic [CW-1:0]    c_reg, c_next;
    logic [NW-1:0]    n_reg, n_next;
    logic [FRAME_BITS-1:0] fr_reg, fr_next;
    logic [FRAME_BITS-1:0] bd_reg, bd_next;

    logic                out_valid_reg, out_valid_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [HELD_W-1:0]   held_reg, held_next;
    logic                poff_reg, poff_next;
    logic                pmap_reg, pmap_next;
    logic [START_W-1:0]  start_reg, start_next;

    cell_ctl_t              ctl;
    logic [WINDOW_CHIPS-1:0] win_w;
    logic [WINDOW_CHIPS-1:0] scan_w;

    logic             full;
    logic             out_free;
    logic             match;
    logic             more;
    logic             pair_bit;

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_CHIPS; gi++)
        begin : g_cell
            em4100_chip_cell #(
                .IDX (gi),
                .FW  (FW)
            ) u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .fill     (fill_reg),
                .win_nb   ((gi < WINDOW_CHIPS - 1) ? win_w[(gi + 1) % WINDOW_CHIPS] : ctl.chip),
                .scan_nb2 ((gi < WINDOW_CHIPS - 2) ? scan_w[(gi + 2) % WINDOW_CHIPS] : 1'b0),
                .win_q    (win_w[gi]),
                .scan_q   (scan_w[gi])
            );
        end
    endgenerate

    assign full     = (fill_reg == FW'(WINDOW_CHIPS));
    assign out_free = !out_valid_reg || tag.ready;
    assign match    = (n_reg >= NW'(FRAME_BITS)) && frame_ok(fr_reg, bd_reg);
    assign more     = ((c_reg + CW'(1)) < {1'b0, fill_reg}) && (n_reg < NW'(WINDOW_BITS));
    assign pair_bit = scan_w[0] ? map_reg : !map_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_PULSE_RST;
            max_reg <= MAX_PULSE_RST;
            hb_reg  <= HALF_BIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_PULSE: min_reg <= cfg_data;
                REG_MAX_PULSE: max_reg <= cfg_data;
                REG_HALF_BIT:  hb_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
        tgt_reg   <= tgt_next;
        thr_reg   <= thr_next;
        step_reg  <= step_next;
        k_reg     <= k_next;
        reps_reg  <= reps_next;
        off_reg   <= off_next;
        map_reg   <= map_next;
        c_reg     <= c_next;
        n_reg     <= n_next;
        fr_reg    <= fr_next;
        bd_reg    <= bd_next;
        id_reg    <= id_next;
        held_reg  <= held_next;
        poff_reg  <= poff_next;
        pmap_reg  <= pmap_next;
        start_reg <= start_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        level_next     = level_reg;
        tgt_next       = tgt_reg;
        thr_next       = thr_reg;
        step_next      = step_reg;
        k_next         = k_reg;
        reps_next      = reps_reg;
        off_next       = off_reg;
        map_next       = map_reg;
        c_next         = c_reg;
        n_next         = n_reg;
        fr_next        = fr_reg;
        bd_next        = bd_reg;
        id_next        = id_reg;
        held_next      = held_reg;
        poff_next      = poff_reg;
        pmap_next      = pmap_reg;
        start_next     = start_reg;
        out_valid_next = out_valid_reg && !tag.ready;
        pulse.ready    = 1'b0;
        ctl            = '0;
        ctl.full       = full;
        ctl.chip       = level_reg;
        ctl.scan_off   = off_reg;

        case (state_reg)
            ST_IDLE:
            begin
                pulse.ready = 1'b1;
                if (pulse.valid)
                begin
                    level_next = pulse.pulse_level;
                    step_next  = (hb_reg == '0) ? DUR_W'(1) : hb_reg;
                    tgt_next   = {1'b0, pulse.pulse_duration}
                               + {1'b0, ((hb_reg == '0) ? DUR_W'(1) : hb_reg) >> 1};
                    thr_next   = {4'b0, (hb_reg == '0) ? DUR_W'(1) : hb_reg};
                    k_next     = 3'd1;
                    reps_next  = '0;
                    if (pulse.pulse_duration < min_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (pulse.pulse_duration > max_reg)
                    begin
                        fill_next = '0;
                    end
                    else
                    begin
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_ROUND:
            begin
                if (thr_reg <= {3'b0, tgt_reg})
                begin
                    reps_next = k_reg;
                    thr_next  = thr_reg + {4'b0, step_reg};
                    k_next    = k_reg + 3'd1;
                end
                if ((thr_reg > {3'b0, tgt_reg}) || (k_reg == 3'd7))
                begin
                    if (thr_reg <= {3'b0, tgt_reg} && k_reg == 3'd7)
                    begin
                        fill_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        if (reps_next == '0)
                        begin
                            reps_next = 3'd1;
                        end
                        state_next = ST_PUSH;
                    end
                end
            end
            ST_PUSH:
            begin
                ctl.push  = 1'b1;
                if (!full)
                begin
                    fill_next = fill_reg + FW'(1);
                end
                reps_next = reps_reg - 3'd1;
                if (reps_reg == 3'd1)
                begin
                    off_next   = 1'b0;
                    map_next   = 1'b0;
                    state_next = (fill_next >= FW'(MIN_CHIPS)) ? ST_LOAD : ST_IDLE;
                end
            end
            ST_LOAD:
            begin
                ctl.scan_load = 1'b1;
                c_next        = {{(CW-1){1'b0}}, off_reg};
                n_next        = '0;
                fr_next       = '0;
                bd_next       = '0;
                state_next    = ST_STEP;
            end
            ST_STEP:
            begin
                if (match)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        id_next        = frame_id(fr_reg);
                        held_next      = HELD_W'(fill_reg);
                        poff_next      = off_reg;
                        pmap_next      = map_reg;
                        start_next     = START_W'(n_reg - NW'(FRAME_BITS));
                        state_next     = ST_IDLE;
                    end
                end
                else if (more)
                begin
                    ctl.scan_shift = 1'b1;
                    fr_next        = {fr_reg[FRAME_BITS-2:0], pair_bit};
                    bd_next        = {bd_reg[FRAME_BITS-2:0], scan_w[0] == scan_w[1]};
                    n_next         = n_reg + NW'(1);
                    c_next         = c_reg + CW'(2);
                end
                else
                begin
                    map_next = !map_reg;
                    if (map_reg)
                    begin
                        off_next = !off_reg;
                    end
                    state_next = (map_reg && off_reg) ? ST_IDLE : ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign tag.valid        = out_valid_reg;
    assign tag.tag_id       = id_reg;
    assign tag.chips_held   = held_reg;
    assign tag.pair_phase   = poff_reg;
    assign tag.polarity_sel = pmap_reg;
    assign tag.header_pos   = start_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(WINDOW_CHIPS))
        else $error("chip fill beyond window size");

    a_result_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP && match && out_free) |-> fill_reg >= FW'(MIN_CHIPS))
        else $error("result with too few chips held");

    a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |-> n_reg <= NW'(WINDOW_BITS))
        else $error("decoded bit count beyond limit");

    a_push_reps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH) |-> (reps_reg != 3'd0 && reps_reg <= 3'(MAX_REPS)))
        else $error("chip repeat count out of range");

endmodule
`default_nettype wire

// ===== rtl/core/em4100_chip_cell.sv =====
// One chip cell: a window bit and a scan bit, each fed by its neighbors.
`default_nettype none
module em4100_chip_cell #(
    parameter int IDX = 0,
    parameter int FW  = 9
) (
    input  wire                    clk,
    input  wire em4100_pkg::cell_ctl_t ctl,
    input  wire [FW-1:0]           fill,
    input  wire                    win_nb,
    input  wire                    scan_nb2,
    output logic                   win_q,
    output logic                   scan_q
);
    import em4100_pkg::*;

    logic win_reg;
    logic scan_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            if (ctl.full)
            begin
                win_reg <= win_nb;
            end
            else if (fill == FW'(IDX))
            begin
                win_reg <= ctl.chip;
            end
        end
        if (ctl.scan_load)
        begin
            scan_reg <= ctl.scan_off ? win_nb : win_reg;
        end
        else if (ctl.scan_shift)
        begin
            scan_reg <= scan_nb2;
        end
    end

    assign win_q  = win_reg;
    assign scan_q = scan_reg;
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the EM4100 pulse frame decoder with its own decode predictor.
`default_nettype none
module tb_top;
    import em4100_pkg::*;

    typedef struct {
        logic [ID_W-1:0]    tag_id;
        logic [HELD_W-1:0]  chips_held;
        logic               pair_phase;
        logic               polarity_sel;
        logic [START_W-1:0] header_pos;
    } tag_result_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [DUR_W-1:0] cfg_data;

    em4100_pulse_if pulse();
    em4100_tag_if   tag();

    em4100_pulse_frame_decoder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pulse     (pulse),
        .tag       (tag),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tag_result_t pending_tags[$];
    bit          chip_win[256];
    int          fill_model;
    int          min_us;
    int          max_us;
    int          half_us;
    bit          dec_val[128];
    bit          dec_bad[128];
    int          failures;
    int          pulses_counted;
    int          tags_checked;
    int          settings_used;
    int          burst_left;
    int          stall_cnt;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic bit frame_at(int s, output logic [ID_W-1:0] id);
        bit       p;
        bit       b;
        bit [3:0] col;
        int       i;
        int       r;
        int       k;
        id  = '0;
        col = '0;
        for (i = 0; i < FRAME_BITS; i++)
        begin
            if (dec_bad[s+i])
            begin
                return 1'b0;
            end
        end
        for (i = 0; i < HDR_ONES; i++)
        begin
            if (!dec_val[s+i])
            begin
                return 1'b0;
            end
        end
        if (dec_val[s+63])
        begin
            return 1'b0;
        end
        for (r = 0; r < ROWS; r++)
        begin
            p = dec_val[s+HDR_ONES+r*5+4];
            for (k = 0; k < 4; k++)
            begin
                b      = dec_val[s+HDR_ONES+r*5+k];
                p      = p ^ b;
                col[k] = col[k] ^ b;
                id     = {id[ID_W-2:0], b};
            end
            if (p)
            begin
                return 1'b0;
            end
        end
        for (k = 0; k < 4; k++)
        begin
            if (col[k] != dec_val[s+COL_BASE+k])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void predict_pulse(bit lvl, int dur);
        int              hb;
        int              reps;
        int              i;
        int              off;
        int              mp;
        int              c;
        int              n;
        int              s;
        logic [ID_W-1:0] id;
        tag_result_t     res;
        hb = (half_us == 0) ? 1 : half_us;
        if (dur < min_us)
        begin
            return;
        end
        if (dur > max_us)
        begin
            fill_model = 0;
            return;
        end
        reps = (dur + hb / 2) / hb;
        if (reps == 0)
        begin
            reps = 1;
        end
        else if (reps > MAX_REPS)
        begin
            fill_model = 0;
            return;
        end
        for (i = 0; i < reps; i++)
        begin
            if (fill_model < 256)
            begin
                chip_win[fill_model] = lvl;
                fill_model++;
            end
            else
            begin
                for (c = 0; c < 255; c++)
                begin
                    chip_win[c] = chip_win[c+1];
                end
                chip_win[255] = lvl;
            end
        end
        if (fill_model < MIN_CHIPS)
        begin
            return;
        end
        for (off = 0; off < 2; off++)
        begin
            for (mp = 0; mp < 2; mp++)
            begin
                n = 0;
                for (c = off; c + 1 < fill_model && n < 128; c += 2)
                begin
                    dec_bad[n] = (chip_win[c] == chip_win[c+1]);
                    dec_val[n] = (chip_win[c] == 1'b0) ? (mp == 0) : (mp != 0);
                    n++;
                end
                for (s = 0; s + FRAME_BITS <= n; s++)
                begin
                    if (frame_at(s, id))
                    begin
                        res.tag_id       = id;
                        res.chips_held   = fill_model[HELD_W-1:0];
                        res.pair_phase   = off[0];
                        res.polarity_sel = mp[0];
                        res.header_pos   = s[START_W-1:0];
                        pending_tags.push_back(res);
                        return;
                    end
                end
            end
        end
    endfunction

    task automatic send_pulse(bit lvl, int dur);
        bit acc;
        if (burst_left == 0)
        begin
            pulse.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                      : $urandom_range(1, 24);
        end
        burst_left--;
        pulse.valid          <= 1'b1;
        pulse.pulse_level    <= lvl;
        pulse.pulse_duration <= dur[DUR_W-1:0];
        do
        begin
            @(negedge clk);
            acc = pulse.ready;
            @(posedge clk);
        end
        while (!acc);
        pulses_counted++;
        predict_pulse(lvl, dur);
    endtask

    task automatic wait_results_done(int settle);
        pulse.valid <= 1'b0;
        while (pending_tags.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_regs(int mn, int mx, int hb);
        wait_results_done(1200);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MIN_PULSE;
        cfg_data  <= mn[DUR_W-1:0];
        @(posedge clk);
        cfg_index <= REG_MAX_PULSE;
        cfg_data  <= mx[DUR_W-1:0];
        @(posedge clk);
        cfg_index <= REG_HALF_BIT;
        cfg_data  <= hb[DUR_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        min_us  = mn;
        max_us  = mx;
        half_us = hb;
        settings_used++;
    endtask

    // Builds a tag transmission of two or three frame repeats and sends it as level runs.
    task automatic send_tag_stream(bit broken, int stop_at);
        bit          frame_bits[64];
        bit          chips[$];
        bit [3:0]    col;
        bit [ID_W-1:0] id;
        bit          mp;
        bit          cur;
        int          i;
        int          r;
        int          k;
        int          rep;
        int          run;
        int          hb;
        int          dur;
        id  = {$urandom(), $urandom()};
        mp  = $urandom_range(0, 1);
        col = '0;
        for (i = 0; i < HDR_ONES; i++)
        begin
            frame_bits[i] = 1'b1;
        end
        for (r = 0; r < ROWS; r++)
        begin
            frame_bits[HDR_ONES+r*5+4] = 1'b0;
            for (k = 0; k < 4; k++)
            begin
                frame_bits[HDR_ONES+r*5+k] = id[ID_W-1-(r*4+k)];
                frame_bits[HDR_ONES+r*5+4] ^= id[ID_W-1-(r*4+k)];
                col[k] ^= id[ID_W-1-(r*4+k)];
            end
        end
        for (k = 0; k < 4; k++)
        begin
            frame_bits[COL_BASE+k] = col[k];
        end
        frame_bits[63] = 1'b0;
        repeat ($urandom_range(0, 3)) chips.push_back($urandom_range(0, 1));
        repeat ($urandom_range(2, 3))
        begin
            for (i = 0; i < FRAME_BITS; i++)
            begin
                cur = frame_bits[i] ^ mp;
                chips.push_back(!cur);
                chips.push_back(cur);
            end
        end
        if (broken)
        begin
            rep = $urandom_range(0, chips.size() - 1);
            chips[rep] = !chips[rep];
        end
        hb = (half_us == 0) ? 1 : half_us;
        i  = 0;
        while (i < chips.size() && pulses_counted < stop_at)
        begin
            cur = chips[i];
            run = 0;
            while (i < chips.size() && chips[i] == cur && run < MAX_REPS)
            begin
                run++;
                i++;
            end
            dur = run * hb + $urandom_range(0, (hb - 1) / 2) - $urandom_range(0, (hb - 1) / 2);
            if (dur > 65535)
            begin
                dur = 65535;
            end
            if (dur < 0)
            begin
                dur = 0;
            end
            send_pulse(cur, dur);
        end
    endtask

    task automatic test_pulse_limits();
        write_regs(MIN_PULSE_RST, MAX_PULSE_RST, HALF_BIT_RST);
        send_pulse(1'b1, 0);
        send_pulse(1'b0, 99);
        send_pulse(1'b1, 100);
        send_pulse(1'b0, 127);
        send_pulse(1'b1, 128);
        send_pulse(1'b0, 1535);
        send_pulse(1'b1, 1663);
        send_pulse(1'b0, 1664);
        send_pulse(1'b1, 1800);
        send_pulse(1'b0, 1801);
        send_pulse(1'b1, 65535);
        send_pulse(1'b0, 512);
        send_pulse(1'b1, 300);
    endtask

    task automatic test_random_traffic(int mn, int mx, int hb, int budget, int noise_pct,
                                       bit hold_off);
        int target;
        write_regs(mn, mx, hb);
        target = pulses_counted + budget;
        while (pulses_counted < target)
        begin
            if (hold_off && pulses_counted > target - budget / 2)
            begin
                wait_results_done(0);
                hold_off = 1'b0;
            end
            if ($urandom_range(1, 100) <= noise_pct)
            begin
                if ($urandom_range(0, 1))
                begin
                    send_pulse($urandom_range(0, 1), $urandom_range(0, 65535));
                end
                else
                begin
                    send_pulse($urandom_range(0, 1), (mx > 60000) ? $urandom_range(mn, 65535)
                                                                   : $urandom_range(0, mx + 10));
                end
            end
            else
            begin
                send_tag_stream($urandom_range(0, 9) == 0, target);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag.ready <= 1'b0;
            stall_cnt <= 0;
        end
        else
        begin
            stall_cnt <= stall_cnt + 1;
            tag.ready <= (stall_cnt[11:10] == 2'd0) ||
                         ((stall_cnt % 7 != 3) && (stall_cnt[5:3] != 3'd5));
        end
    end

    always @(negedge clk)
    begin
        tag_result_t exp_tag;
        if (rst_n && tag.valid && tag.ready)
        begin
            if (pending_tags.size() == 0)
            begin
                $error("unexpected tag result, tag_id %h", tag.tag_id);
                failures++;
            end
            else
            begin
                exp_tag = pending_tags.pop_front();
                tags_checked++;
                if (tag.tag_id !== exp_tag.tag_id)
                begin
                    $error("tag_id expected %h actual %h", exp_tag.tag_id, tag.tag_id);
                    failures++;
                end
                if (tag.chips_held !== exp_tag.chips_held)
                begin
                    $error("chips_held expected %0d actual %0d", exp_tag.chips_held,
                           tag.chips_held);
                    failures++;
                end
                if (tag.pair_phase !== exp_tag.pair_phase)
                begin
                    $error("pair_phase expected %0d actual %0d", exp_tag.pair_phase,
                           tag.pair_phase);
                    failures++;
                end
                if (tag.polarity_sel !== exp_tag.polarity_sel)
                begin
                    $error("polarity_sel expected %0d actual %0d", exp_tag.polarity_sel,
                           tag.polarity_sel);
                    failures++;
                end
                if (tag.header_pos !== exp_tag.header_pos)
                begin
                    $error("header_pos expected %0d actual %0d", exp_tag.header_pos,
                           tag.header_pos);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        #60000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = REG_MIN_PULSE;
        cfg_data             = '0;
        pulse.valid          = 1'b0;
        pulse.pulse_level    = 1'b0;
        pulse.pulse_duration = '0;
        failures             = 0;
        pulses_counted       = 0;
        tags_checked         = 0;
        settings_used        = 0;
        burst_left           = 0;
        fill_model           = 0;
        min_us               = MIN_PULSE_RST;
        max_us               = MAX_PULSE_RST;
        half_us              = HALF_BIT_RST;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_pulse_limits();
        test_random_traffic(100, 1800, 256, 400, 15, 1'b1);
        test_random_traffic(0, 65535, 1, 250, 10, 1'b0);
        test_random_traffic(0, 3, 0, 100, 10, 1'b0);
        test_random_traffic(300, 600, 100, 300, 20, 1'b0);
        test_random_traffic(0, 0, 7, 40, 100, 1'b0);
        test_random_traffic(65535, 65535, 65535, 30, 100, 1'b0);
        wait_results_done(1200);
        if (pending_tags.size() > 0)
        begin
            failures++;
        end
        $display("Run covered %0d counted pulse requests and %0d checked tag results",
                 pulses_counted, tags_checked);
        $display("over %0d register settings, including limit and degenerate values.",
                 settings_used);
        if (failures == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
